>>> rtl/btb_pkg.sv
// Package for the blocked transpose buffer: word structs, config struct,
// register map codes and default sizes. No dependencies.
package btb_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int ELEM_WIDTH_DEF  = 32;

  // Z block sizes for full (32-bit) and half (16-bit) elements
  localparam int ZB_FULL = 8;
  localparam int ZB_HALF = 16;

  localparam int IDX_W  = 28;  // wide enough for any input index the counters can form
  localparam int OIDX_W = 12;

  localparam logic [6:0]  RST_BLOCK_SIZE_XY = 7'd8;
  localparam logic [6:0]  RST_NUM_XY_BLOCKS = 7'd1;
  localparam logic [12:0] RST_NUM_Z         = 13'd16;
  localparam logic        RST_HALF_MODE     = 1'b0;

  typedef enum logic [1:0] {
    REG_BLOCK_SIZE_XY = 2'd0,
    REG_NUM_XY_BLOCKS = 2'd1,
    REG_NUM_Z         = 2'd2,
    REG_HALF_MODE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        command;
    logic [31:0] data_in;
  } in_t;

  typedef struct packed {
    logic [31:0]       data_out;
    logic [OIDX_W-1:0] out_index;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [6:0]  block_size_xy;
    logic [6:0]  num_xy_blocks;
    logic [12:0] num_z;
    logic        half_mode;
  } cfg_t;

  // Read request from the address pipeline to the store
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  in_idx;
    logic [OIDX_W-1:0] out_index;
    logic              last;
  } rd_req_t;

endpackage

>>> rtl/btb_regs.sv
// Configuration registers behind the APB-style port.
// Depends on btb_pkg.
module btb_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output btb_pkg::cfg_t      cfg
);

  btb_pkg::reg_idx_t sel;
  logic              wr;

  assign sel    = btb_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size_xy <= btb_pkg::RST_BLOCK_SIZE_XY;
      cfg.num_xy_blocks <= btb_pkg::RST_NUM_XY_BLOCKS;
      cfg.num_z         <= btb_pkg::RST_NUM_Z;
      cfg.half_mode     <= btb_pkg::RST_HALF_MODE;
    end else if (wr) begin
      case (sel)
        btb_pkg::REG_BLOCK_SIZE_XY: cfg.block_size_xy <= pwdata[6:0];
        btb_pkg::REG_NUM_XY_BLOCKS: cfg.num_xy_blocks <= pwdata[6:0];
        btb_pkg::REG_NUM_Z:         cfg.num_z         <= pwdata[12:0];
        btb_pkg::REG_HALF_MODE:     cfg.half_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      btb_pkg::REG_BLOCK_SIZE_XY: prdata = {25'd0, cfg.block_size_xy};
      btb_pkg::REG_NUM_XY_BLOCKS: prdata = {25'd0, cfg.num_xy_blocks};
      btb_pkg::REG_NUM_Z:         prdata = {19'd0, cfg.num_z};
      btb_pkg::REG_HALF_MODE:     prdata = {31'd0, cfg.half_mode};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/btb_walk.sv
// Output walk: four nested counters and a three-stage index pipeline that
// turns counter values into the input index and the output index.
// Depends on btb_pkg.
module btb_walk (
  input  logic             clk,
  input  logic             rst,
  input  btb_pkg::cfg_t    cfg,
  input  logic             emit,
  output btb_pkg::rd_req_t rd
);

  // walk counters
  logic [6:0] xy_block_count;
  logic [9:0] z_block_count;
  logic [6:0] xy_elem_count;
  logic [4:0] z_elem_count;

  logic [4:0] bz;
  logic [9:0] nbz;
  logic       empty, go;
  logic       ze_wrap, xye_wrap, zb_wrap, xyb_wrap;

  assign bz    = cfg.half_mode ? 5'(btb_pkg::ZB_HALF) : 5'(btb_pkg::ZB_FULL);
  assign nbz   = cfg.half_mode ? {1'b0, cfg.num_z[12:4]} : cfg.num_z[12:3];
  assign empty = (cfg.block_size_xy == 7'd0) || (cfg.num_xy_blocks == 7'd0)
                 || (nbz == 10'd0);
  assign go    = emit && !empty;

  // a counter at or past the last value below its bound wraps on its next step
  assign ze_wrap  = ({1'b0, z_elem_count} + 6'd1) >= {1'b0, bz};
  assign xye_wrap = ({1'b0, xy_elem_count} + 8'd1) >= {1'b0, cfg.block_size_xy};
  assign zb_wrap  = ({1'b0, z_block_count} + 11'd1) >= {1'b0, nbz};
  assign xyb_wrap = ({1'b0, xy_block_count} + 8'd1) >= {1'b0, cfg.num_xy_blocks};

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_block_count <= '0;
      z_block_count  <= '0;
      xy_elem_count  <= '0;
      z_elem_count   <= '0;
    end else if (go) begin
      z_elem_count <= ze_wrap ? 5'd0 : z_elem_count + 5'd1;
      if (ze_wrap) begin
        xy_elem_count <= xye_wrap ? 7'd0 : xy_elem_count + 7'd1;
        if (xye_wrap) begin
          z_block_count <= zb_wrap ? 10'd0 : z_block_count + 10'd1;
          if (zb_wrap) begin
            xy_block_count <= xyb_wrap ? 7'd0 : xy_block_count + 7'd1;
          end
        end
      end
    end
  end

  // stage 1: snapshot of the counters
  logic       s1_valid, s1_last;
  logic [9:0] s1_zb;
  logic [4:0] s1_ze;
  logic [6:0] s1_xyb, s1_xye;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    s1_zb   <= z_block_count;
    s1_ze   <= z_elem_count;
    s1_xyb  <= xy_block_count;
    s1_xye  <= xy_elem_count;
    s1_last <= ze_wrap && xye_wrap && zb_wrap && xyb_wrap;
  end

  logic [13:0] zb_sh, z_row, xy_off, nxy;
  logic [11:0] z_term, lo_term, xye_sh;

  assign zb_sh   = cfg.half_mode ? {s1_zb, 4'd0} : {1'b0, s1_zb, 3'd0};
  assign z_row   = zb_sh + 14'(s1_ze);
  assign xy_off  = 14'(s1_xyb) * 14'(cfg.block_size_xy);
  assign nxy     = 14'(cfg.num_xy_blocks) * 14'(cfg.block_size_xy);
  assign z_term  = zb_sh[11:0] * 12'(cfg.block_size_xy);   // mod 4096 is all we need
  assign xye_sh  = cfg.half_mode ? {1'b0, s1_xye, 4'd0} : {2'b0, s1_xye, 3'd0};
  assign lo_term = xye_sh + 12'(s1_ze);

  // stage 2: partial products
  logic        s2_valid, s2_last;
  logic [13:0] s2_z, s2_xy_off, s2_nxy;
  logic [6:0]  s2_xye;
  logic [11:0] s2_z_term, s2_lo_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_z       <= z_row;
    s2_xy_off  <= xy_off;
    s2_nxy     <= nxy;
    s2_xye     <= s1_xye;
    s2_z_term  <= z_term;
    s2_lo_term <= lo_term;
    s2_last    <= s1_last;
  end

  logic [btb_pkg::IDX_W-1:0]  in_idx;
  logic [btb_pkg::OIDX_W-1:0] out_idx;

  assign in_idx  = btb_pkg::IDX_W'(s2_z) * btb_pkg::IDX_W'(s2_nxy)
                 + btb_pkg::IDX_W'(s2_xy_off) + btb_pkg::IDX_W'(s2_xye);
  assign out_idx = s2_xy_off[11:0] * cfg.num_z[11:0] + s2_z_term + s2_lo_term;

  // stage 3: read request
  always_ff @(posedge clk) begin
    if (rst) begin
      rd.valid <= 1'b0;
    end else begin
      rd.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd.in_idx    <= in_idx;
    rd.out_index <= out_idx;
    rd.last      <= s2_last;
  end

endmodule

>>> rtl/btb_store.sv
// Element store with load pointer, registered read port and result register.
// Depends on btb_pkg.
module btb_store #(
  parameter int STORE_DEPTH = btb_pkg::STORE_DEPTH_DEF,
  parameter int ELEM_WIDTH  = btb_pkg::ELEM_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [31:0]      load_data,
  input  logic             half_mode,
  input  btb_pkg::rd_req_t rd,
  output logic             done,
  output btb_pkg::out_t    rsp
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = $clog2(STORE_DEPTH + 1);

  logic [ELEM_WIDTH-1:0] mem [STORE_DEPTH];
  logic [PW-1:0]         load_pointer;
  logic                  room;
  logic [ELEM_WIDTH-1:0] wmask, wdata;

  assign room  = load_pointer < PW'(STORE_DEPTH);
  assign wmask = ELEM_WIDTH'(half_mode ? 32'h0000_FFFF : 32'hFFFF_FFFF);
  assign wdata = load_data[ELEM_WIDTH-1:0] & wmask;

  // loads past capacity are dropped; pointer parks at the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
    end else if (load && room) begin
      load_pointer <= load_pointer + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      mem[load_pointer[AW-1:0]] <= wdata;
    end
  end

  // read stage
  logic                       q_valid, q_in_range, q_last;
  logic [ELEM_WIDTH-1:0]      q_data;
  logic [btb_pkg::OIDX_W-1:0] q_out_index;

  always_ff @(posedge clk) begin
    q_data      <= mem[rd.in_idx[AW-1:0]];
    q_in_range  <= rd.in_idx < btb_pkg::IDX_W'(STORE_DEPTH);
    q_out_index <= rd.out_index;
    q_last      <= rd.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      q_valid <= rd.valid;
      done    <= q_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    rsp.data_out  <= q_in_range ? 32'(q_data) : 32'd0;
    rsp.out_index <= q_out_index;
    rsp.last      <= q_last;
  end

endmodule

>>> rtl/block_transpose_buffer.sv
// Top level of the blocked transpose buffer: config port, walk pipeline and
// element store. Depends on btb_pkg, btb_regs, btb_walk, btb_store.
//
//  channel   signals                       direction  handshake
//  --------  ----------------------------  ---------  ----------------------------
//  command   start, busy, req (in_t)       in         taken when start && !busy
//  result    done, rsp (out_t)             out        one-cycle strobe, no stall
//  config    psel penable pwrite paddr     in/out     APB write in setup+access,
//            pwdata prdata pready                     pready tied high
//
// One word per cycle: busy never rises, so a load or emit can be issued every
// clock. A load writes the store at the accepting edge. An emit's result passes
// through counter snapshot, partial products, index products, store read and
// result register to done/rsp. Loads and emits with an empty walk produce no
// result. Synchronous reset clears the walk counters, the load pointer and the
// pipeline valid bits and restores the config defaults; the store is not cleared
// (the user must write entries before they are read; the block does not enforce
// it). The receiver cannot stall, so no backpressure path exists.
module block_transpose_buffer #(
  parameter int STORE_DEPTH = btb_pkg::STORE_DEPTH_DEF,
  parameter int ELEM_WIDTH  = btb_pkg::ELEM_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  btb_pkg::in_t  req,
  output logic          done,
  output btb_pkg::out_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  btb_pkg::cfg_t    cfg;
  btb_pkg::rd_req_t rd;
  logic             accept, load, emit;

  // fully pipelined: never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign load   = accept && !req.command;
  assign emit   = accept && req.command;

  btb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // counters advance at acceptance; index math runs behind them
  btb_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .emit (emit),
    .rd   (rd)
  );

  btb_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_data (req.data_in),
    .half_mode (cfg.half_mode),
    .rd        (rd),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

>>> rtl/btb_checker.sv
// Port-level checks for block_transpose_buffer, bound to the top level.
// Depends on btb_pkg.
module btb_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input btb_pkg::in_t  req,
  input logic          done,
  input btb_pkg::out_t rsp,
  input logic          psel,
  input logic          penable,
  input logic          pwrite,
  input logic [3:0]    paddr,
  input logic [31:0]   pwdata,
  input logic [31:0]   prdata,
  input logic          pready
);

  // a result only ever follows an accepted emit word
  a_done_from_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && req.command, 5))
    else $error("result without matching emit word");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

  // block size register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[3:2] == 2'd0) ##1 (paddr[3:2] == 2'd0)
    |-> prdata[6:0] == $past(pwdata[6:0]))
    else $error("block size readback mismatch");

  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

  // a result word carries no unknown bits
  a_rsp_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(rsp))
    else $error("result word has unknown bits");

endmodule

bind block_transpose_buffer btb_checker u_btb_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .req     (req),
  .done    (done),
  .rsp     (rsp),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata),
  .pready  (pready)
);
